// ===== design/cnsa_pkg.sv =====
// Shared types, constants and codes of the channel noise statistics accumulator.
package cnsa_pkg;

	localparam int DEF_ENTRIES     = 32768;
	localparam int DEF_MAX_SAMPLES = 16;
	localparam int DEF_SAMPLE_BITS = 10;
	localparam int DEF_COUNT_BITS  = 24;

	localparam int FRAC_BITS  = 8;
	localparam int ENTRY_W    = 15;
	localparam int SAMPLE_W   = 10;
	localparam int DB_W       = 18;
	localparam int NOISE_W    = 18;
	localparam int PED_W      = 19;
	localparam int IN_DATA_W  = 88;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 80;
	localparam int CFG_IDX_W  = 1;
	localparam int QDEPTH     = 4;
	localparam int PED_LIMIT  = 262143;

	localparam logic [NOISE_W-1:0] NOISE_MAX = '1;

	localparam logic ACT_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FILL_EMPTY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SUB_DB_PED = 1'b1;

	typedef struct packed {
		logic                action;
		logic [ENTRY_W-1:0]  entry;
		logic [SAMPLE_W-1:0] sample;
		logic [2*SAMPLE_W-1:0] square;
		logic                first;
		logic                last;
		logic                good;
		logic                disc;
		logic                ok;
		logic [DB_W-1:0]     db_ped;
		logic [DB_W-1:0]     db_lfn;
		logic [DB_W-1:0]     db_hfn;
	} item_t;

	typedef struct packed {
		logic [NOISE_W-1:0] err;
		logic [PED_W-1:0]   ped;
		logic [NOISE_W-1:0] hfn;
		logic [NOISE_W-1:0] lfn;
	} res_t;

	typedef struct packed {
		logic fill_empty;
		logic sub_db_ped;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_HFN,
		ST_PED,
		ST_MNQ,
		ST_MSS,
		ST_MD,
		ST_VDIV,
		ST_SQ1,
		ST_NDIV,
		ST_SQ2,
		ST_RMSW,
		ST_OUT
	} state_t;

endpackage

// ===== design/cnsa_front.sv =====
// Front end: unpacks requests, masks and squares the sample, checks the entry range.
module cnsa_front #(
	parameter int ENTRIES     = cnsa_pkg::DEF_ENTRIES,
	parameter int SAMPLE_BITS = cnsa_pkg::DEF_SAMPLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cnsa_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [cnsa_pkg::IN_USER_W-1:0]  s_tuser,
	input  logic                            s_tlast,
	input  logic                            clearing,
	output logic                            q_valid,
	input  logic                            q_ready,
	output cnsa_pkg::item_t                 q_item
);
	import cnsa_pkg::*;

	logic                v_s1;
	item_t               item_s1;
	item_t               item_in;
	logic [SAMPLE_W-1:0] smask;
	logic [SAMPLE_W-1:0] sm;
	logic                take;

	always_comb begin
		for (int i = 0; i < SAMPLE_W; i++) begin
			smask[i] = (i < SAMPLE_BITS);
		end
		sm = s_tdata[24:15] & smask;
		item_in.action = s_tuser[0];
		item_in.first  = s_tuser[1];
		item_in.last   = s_tlast;
		item_in.entry  = s_tdata[14:0];
		item_in.sample = sm;
		item_in.square = (2*SAMPLE_W)'(sm) * (2*SAMPLE_W)'(sm);
		item_in.good   = s_tdata[25];
		item_in.disc   = s_tdata[26];
		item_in.ok     = (32'(s_tdata[14:0]) < 32'(ENTRIES));
		item_in.db_ped = s_tdata[44:27];
		item_in.db_lfn = s_tdata[62:45];
		item_in.db_hfn = s_tdata[80:63];
	end

	assign s_tready = !clearing && (!v_s1 || q_ready);
	assign take     = s_tvalid && s_tready;
	assign q_valid  = v_s1;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (q_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ===== design/cnsa_queue.sv =====
// Short request queue between the front end and the back end.
module cnsa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cnsa_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_pop,
	output cnsa_pkg::item_t out_item
);
	import cnsa_pkg::*;

	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	item_t          slot_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           pop;

	assign in_ready  = (cnt_q != QCW'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_item  = slot_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_item;
		end
	end

endmodule

// ===== design/cnsa_calc.sv =====
// Shared serial arithmetic unit: shift-add multiply, restoring divide, bitwise square root.
module cnsa_calc #(
	parameter int XW = 84
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  cnsa_pkg::op_t      op,
	input  logic [XW-1:0]      a,
	input  logic [XW-1:0]      b,
	output logic               done,
	output logic [XW-1:0]      res
);
	import cnsa_pkg::*;

	localparam int CW = $clog2(XW + 1);

	logic          busy_q;
	op_t           op_q;
	logic [CW-1:0] cnt_q;
	logic [XW-1:0] a_q;
	logic [XW-1:0] b_q;
	logic [XW-1:0] acc_q;
	logic [XW:0]   rem_q;
	logic          fin;
	logic [XW:0]   dtrial;
	logic          dge;
	logic [XW:0]   srem;
	logic [XW:0]   strial;
	logic          sge;

	always_comb begin
		fin    = busy_q && ((op_q == OP_MUL) ? (b_q == '0) : (cnt_q == '0));
		dtrial = {rem_q[XW-1:0], a_q[XW-1]};
		dge    = (dtrial >= {1'b0, b_q});
		srem   = {rem_q[XW-2:0], a_q[XW-1:XW-2]};
		strial = {acc_q[XW-2:0], 2'b01};
		sge    = (srem >= strial);
	end

	assign done = fin;
	assign res  = (op_q == OP_DIV) ? a_q : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (go) begin
			busy_q <= 1'b1;
		end else if (fin) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			op_q  <= op;
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
			rem_q <= '0;
			cnt_q <= (op == OP_SQRT) ? CW'(XW / 2) : CW'(XW);
		end else if (busy_q && !fin) begin
			case (op_q)
				OP_MUL: begin
					if (b_q[0]) begin
						acc_q <= acc_q + a_q;
					end
					a_q <= a_q << 1;
					b_q <= b_q >> 1;
				end
				OP_DIV: begin
					rem_q <= dge ? (dtrial - {1'b0, b_q}) : dtrial;
					a_q   <= {a_q[XW-2:0], dge};
					cnt_q <= cnt_q - 1'b1;
				end
				OP_SQRT: begin
					rem_q <= sge ? (srem - strial) : srem;
					acc_q <= {acc_q[XW-2:0], sge};
					a_q   <= a_q << 2;
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

endmodule

// ===== design/cnsa_back.sv =====
// Back end: statistics store, open readout, request sequencer and result register.
module cnsa_back #(
	parameter int ENTRIES     = cnsa_pkg::DEF_ENTRIES,
	parameter int MAX_SAMPLES = cnsa_pkg::DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = cnsa_pkg::DEF_SAMPLE_BITS,
	parameter int COUNT_BITS  = cnsa_pkg::DEF_COUNT_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cnsa_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  cnsa_pkg::item_t q_item,
	output logic            q_pop,
	output logic            clearing,
	output logic            res_valid,
	input  logic            res_ready,
	output cnsa_pkg::res_t  res
);
	import cnsa_pkg::*;

	localparam int SB   = SAMPLE_BITS;
	localparam int CB   = COUNT_BITS;
	localparam int AW   = $clog2(ENTRIES);
	localparam int PSW  = SB + CB;
	localparam int PQW  = 2 * SB + CB;
	localparam int RSW  = SB + FRAC_BITS + CB;
	localparam int RLW  = SB + FRAC_BITS;
	localparam int XW   = 2 * SB + 2 * CB + 16;
	localparam int RNW  = $clog2(MAX_SAMPLES + 1);
	localparam int ROSW = SB + RNW;
	localparam int ROQW = 2 * SB + RNW;
	localparam int PDW  = PSW + FRAC_BITS + 2;

	localparam logic [RLW-1:0]        RL_MAX = '1;
	localparam logic signed [PDW-1:0] PLIM   = PDW'(PED_LIMIT);

	typedef struct packed {
		logic [PSW-1:0] ps;
		logic [PQW-1:0] pq;
		logic [RSW-1:0] rs;
		logic [CB-1:0]  pc;
		logic [CB-1:0]  rc;
	} rec_t;

	rec_t mem [ENTRIES];

	state_t          st_q;
	state_t          nxt;
	logic [AW-1:0]   clr_q;
	logic            launched_q;
	item_t           item_q;
	rec_t            rd_q;
	rec_t            rec;
	logic            rd_en;
	logic            we;
	logic [AW-1:0]   waddr;
	rec_t            wdata;

	logic [ROSW-1:0] rsum_q;
	logic [ROQW-1:0] rsq_q;
	logic [RNW-1:0]  rn_q;
	logic            rgood_q;
	logic [ROSW-1:0] ro_s;
	logic [ROQW-1:0] ro_q;
	logic [RNW-1:0]  ro_n;
	logic            ro_g;
	logic            ro_ignore;
	logic            rms_go;

	logic [CB-1:0]   opn_q;
	logic [PSW-1:0]  ops_q;
	logic [PQW-1:0]  opq_q;
	logic [XW-1:0]   nq_q;
	logic [XW-1:0]   x_q;
	logic [XW-1:0]   d_q;
	logic [XW-1:0]   v_q;
	logic [XW-1:0]   pdiv_q;
	logic [RLW-1:0]  rr_q;
	logic [NOISE_W-1:0] lfn_q;
	logic [NOISE_W-1:0] err_q;
	logic [NOISE_W-1:0] hfn_q;

	logic            go;
	op_t             c_op;
	logic [XW-1:0]   c_a;
	logic [XW-1:0]   c_b;
	logic            c_done;
	logic [XW-1:0]   c_res;

	logic            is_read;
	logic            mv_q;
	res_t            res_q;
	res_t            res_n;
	logic            out_free;

	logic [SB-1:0]   samp;
	logic [2*SB-1:0] sq;
	logic [PSW:0]    ps_sum;
	logic [PQW:0]    pq_sum;
	logic [CB:0]     pc_sum;
	logic [RSW:0]    rs_sum;
	logic [CB:0]     rc_sum;
	logic            fill;
	logic signed [PDW-1:0] pe;
	logic signed [PDW-1:0] pd;

	function automatic logic [NOISE_W-1:0] sat_noise(input logic [XW-1:0] v);
		return (v > XW'(NOISE_MAX)) ? NOISE_MAX : v[NOISE_W-1:0];
	endfunction

	cnsa_calc #(.XW(XW)) u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.op     (c_op),
		.a      (c_a),
		.b      (c_b),
		.done   (c_done),
		.res    (c_res)
	);

	assign clearing  = (st_q == ST_CLEAR);
	assign res_valid = mv_q;
	assign res       = res_q;
	assign out_free  = !mv_q || res_ready;
	assign is_read   = (item_q.action == ACT_READ);
	assign rec       = item_q.ok ? rd_q : '0;
	assign samp      = SB'(item_q.sample);
	assign sq        = (2*SB)'(item_q.square);
	assign fill      = cfg.fill_empty && item_q.good;

	always_comb begin
		ps_sum = {1'b0, rec.ps} + (PSW+1)'(samp);
		pq_sum = {1'b0, rec.pq} + (PQW+1)'(sq);
		pc_sum = {1'b0, rec.pc} + (CB+1)'(1);
		rs_sum = {1'b0, rec.rs} + (RSW+1)'(rr_q);
		rc_sum = {1'b0, rec.rc} + (CB+1)'(1);
	end

	always_comb begin
		ro_ignore = !item_q.first && (rn_q == '0);
		if (item_q.first) begin
			ro_s = ROSW'(samp);
			ro_q = ROQW'(sq);
			ro_n = RNW'(1);
			ro_g = item_q.good;
		end else begin
			ro_g = rgood_q && item_q.good;
			if (rn_q < RNW'(MAX_SAMPLES)) begin
				ro_s = rsum_q + ROSW'(samp);
				ro_q = rsq_q + ROQW'(sq);
				ro_n = rn_q + 1'b1;
			end else begin
				ro_s = rsum_q;
				ro_q = rsq_q;
				ro_n = rn_q;
			end
		end
		rms_go = item_q.last && !ro_ignore && ro_g && (ro_n >= RNW'(2)) && item_q.ok;
	end

	always_comb begin
		pe = $signed({2'b00, pdiv_q[PSW+FRAC_BITS-1:0]});
		if (cfg.sub_db_ped) begin
			pd = item_q.disc ? '0 : (pe - $signed(PDW'(item_q.db_ped)));
		end else begin
			pd = pe;
		end
		if (rec.pc > CB'(1)) begin
			res_n.lfn = lfn_q;
			res_n.err = err_q;
			if (pd > PLIM) begin
				res_n.ped = PED_W'(PLIM);
			end else if (pd < -PLIM) begin
				res_n.ped = PED_W'(-PLIM);
			end else begin
				res_n.ped = pd[PED_W-1:0];
			end
		end else begin
			res_n.lfn = fill ? item_q.db_lfn : '0;
			res_n.err = '0;
			res_n.ped = '0;
		end
		res_n.hfn = (rec.rc != '0) ? hfn_q : (fill ? item_q.db_hfn : '0);
	end

	always_comb begin
		nxt   = st_q;
		go    = 1'b0;
		c_op  = OP_MUL;
		c_a   = '0;
		c_b   = '0;
		q_pop = 1'b0;
		rd_en = 1'b0;
		we    = 1'b0;
		waddr = AW'(item_q.entry);
		wdata = rec;
		case (st_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == AW'(ENTRIES - 1)) begin
					nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					rd_en = 1'b1;
					nxt   = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (is_read) begin
					if (rec.rc != '0) begin
						nxt = ST_HFN;
					end else if (rec.pc > CB'(1)) begin
						nxt = ST_PED;
					end else begin
						nxt = ST_OUT;
					end
				end else begin
					if (item_q.first && item_q.ok && item_q.good) begin
						we       = 1'b1;
						wdata.ps = ps_sum[PSW] ? '1 : ps_sum[PSW-1:0];
						wdata.pq = pq_sum[PQW] ? '1 : pq_sum[PQW-1:0];
						wdata.pc = pc_sum[CB] ? '1 : pc_sum[CB-1:0];
					end
					nxt = rms_go ? ST_MNQ : ST_IDLE;
				end
			end
			ST_HFN: begin
				go   = !launched_q;
				c_op = OP_DIV;
				c_a  = XW'(rec.rs);
				c_b  = XW'(rec.rc);
				if (c_done) begin
					nxt = (rec.pc > CB'(1)) ? ST_PED : ST_OUT;
				end
			end
			ST_PED: begin
				go   = !launched_q;
				c_op = OP_DIV;
				c_a  = XW'(ops_q) << FRAC_BITS;
				c_b  = XW'(opn_q);
				if (c_done) begin
					nxt = ST_MNQ;
				end
			end
			ST_MNQ: begin
				go   = !launched_q;
				c_op = OP_MUL;
				c_a  = XW'(opn_q);
				c_b  = XW'(opq_q);
				if (c_done) begin
					nxt = ST_MSS;
				end
			end
			ST_MSS: begin
				go   = !launched_q;
				c_op = OP_MUL;
				c_a  = XW'(ops_q);
				c_b  = XW'(ops_q);
				if (c_done) begin
					if (c_res >= nq_q) begin
						nxt = is_read ? ST_OUT : ST_RMSW;
					end else begin
						nxt = ST_MD;
					end
				end
			end
			ST_MD: begin
				go   = !launched_q;
				c_op = OP_MUL;
				c_a  = XW'(opn_q);
				c_b  = XW'(opn_q - CB'(1));
				if (c_done) begin
					nxt = ST_VDIV;
				end
			end
			ST_VDIV: begin
				go   = !launched_q;
				c_op = OP_DIV;
				c_a  = x_q;
				c_b  = d_q;
				if (c_done) begin
					nxt = ST_SQ1;
				end
			end
			ST_SQ1: begin
				go   = !launched_q;
				c_op = OP_SQRT;
				c_a  = v_q;
				if (c_done) begin
					nxt = is_read ? ST_NDIV : ST_RMSW;
				end
			end
			ST_NDIV: begin
				go   = !launched_q;
				c_op = OP_DIV;
				c_a  = v_q;
				c_b  = XW'(opn_q);
				if (c_done) begin
					nxt = ST_SQ2;
				end
			end
			ST_SQ2: begin
				go   = !launched_q;
				c_op = OP_SQRT;
				c_a  = v_q;
				if (c_done) begin
					nxt = ST_OUT;
				end
			end
			ST_RMSW: begin
				we       = 1'b1;
				wdata.rs = rs_sum[RSW] ? '1 : rs_sum[RSW-1:0];
				wdata.rc = rc_sum[CB] ? '1 : rc_sum[CB-1:0];
				nxt      = ST_IDLE;
			end
			ST_OUT: begin
				if (out_free) begin
					nxt = ST_IDLE;
				end
			end
			default: begin
				nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLEAR;
			clr_q      <= '0;
			launched_q <= 1'b0;
			mv_q       <= 1'b0;
			rsum_q     <= '0;
			rsq_q      <= '0;
			rn_q       <= '0;
			rgood_q    <= 1'b0;
		end else begin
			st_q <= nxt;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (go) begin
				launched_q <= 1'b1;
			end else if (c_done) begin
				launched_q <= 1'b0;
			end
			if (st_q == ST_OUT && out_free) begin
				mv_q <= 1'b1;
			end else if (res_ready) begin
				mv_q <= 1'b0;
			end
			if (st_q == ST_FETCH && !is_read && !ro_ignore) begin
				if (item_q.last) begin
					rsum_q  <= '0;
					rsq_q   <= '0;
					rn_q    <= '0;
					rgood_q <= 1'b0;
				end else begin
					rsum_q  <= ro_s;
					rsq_q   <= ro_q;
					rn_q    <= ro_n;
					rgood_q <= ro_g;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[AW'(q_item.entry)];
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid) begin
			item_q <= q_item;
		end
		if (st_q == ST_OUT && out_free) begin
			res_q <= res_n;
		end
		case (st_q)
			ST_FETCH: begin
				if (is_read) begin
					opn_q <= rec.pc;
					ops_q <= rec.ps;
					opq_q <= rec.pq;
				end else begin
					opn_q <= CB'(ro_n);
					ops_q <= PSW'(ro_s);
					opq_q <= PQW'(ro_q);
				end
			end
			ST_HFN: begin
				if (c_done) begin
					hfn_q <= sat_noise(c_res);
				end
			end
			ST_PED: begin
				if (c_done) begin
					pdiv_q <= c_res;
				end
			end
			ST_MNQ: begin
				if (c_done) begin
					nq_q <= c_res;
				end
			end
			ST_MSS: begin
				if (c_done) begin
					x_q   <= (nq_q - c_res) << 16;
					lfn_q <= '0;
					err_q <= '0;
					rr_q  <= '0;
				end
			end
			ST_MD: begin
				if (c_done) begin
					d_q <= c_res;
				end
			end
			ST_VDIV, ST_NDIV: begin
				if (c_done) begin
					v_q <= c_res;
				end
			end
			ST_SQ1: begin
				if (c_done) begin
					lfn_q <= sat_noise(c_res);
					rr_q  <= (c_res > XW'(RL_MAX)) ? RL_MAX : c_res[RLW-1:0];
				end
			end
			ST_SQ2: begin
				if (c_done) begin
					err_q <= sat_noise(c_res);
				end
			end
			default: begin
				rr_q <= rr_q;
			end
		endcase
	end

endmodule

// ===== design/channel_noise_statistics_accumulator.sv =====
// Top level of the channel noise statistics accumulator.
// Path: an accepted request passes the front-end register and the queue into the back end.
// An accumulate request reads and updates its store row; one that closes a readout of two or
// more samples also runs multiply, divide and square root steps in the serial unit of width
// XW = 2*SAMPLE_BITS + 2*COUNT_BITS + 16 (84 by default). A read runs its steps in that unit too.
// The back end serves one request at a time, all of them sharing that unit.
// Reset: asynchronous; afterwards a clearing pass writes zeros to all ENTRIES store rows,
// one per cycle, while no request is accepted; configuration writes are taken throughout.
module channel_noise_statistics_accumulator #(
	parameter int ENTRIES     = cnsa_pkg::DEF_ENTRIES,
	parameter int MAX_SAMPLES = cnsa_pkg::DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = cnsa_pkg::DEF_SAMPLE_BITS,
	parameter int COUNT_BITS  = cnsa_pkg::DEF_COUNT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cnsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic                            cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// entry, sample, entry_good, disconnected, db_pedestal, db_low_freq_noise,
	// db_high_freq_noise, zero fill
	input  logic [cnsa_pkg::IN_DATA_W-1:0]  s_tdata,
	// action, first_sample
	input  logic [cnsa_pkg::IN_USER_W-1:0]  s_tuser,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// low_freq_noise, high_freq_noise, pedestal, pedestal uncertainty, zero fill
	output logic [cnsa_pkg::OUT_DATA_W-1:0] m_tdata
);
	import cnsa_pkg::*;

	cfg_t  cfg_q;
	logic  clearing;
	logic  f_valid;
	logic  f_ready;
	item_t f_item;
	logic  b_valid;
	logic  b_pop;
	item_t b_item;
	res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fill_empty <= 1'b0;
			cfg_q.sub_db_ped <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILL_EMPTY: cfg_q.fill_empty <= cfg_data;
				REG_SUB_DB_PED: cfg_q.sub_db_ped <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	cnsa_front #(
		.ENTRIES     (ENTRIES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.clearing (clearing),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_item   (f_item)
	);

	cnsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (b_valid),
		.out_pop   (b_pop),
		.out_item  (b_item)
	);

	cnsa_back #(
		.ENTRIES     (ENTRIES),
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (b_valid),
		.q_item    (b_item),
		.q_pop     (b_pop),
		.clearing  (clearing),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = OUT_DATA_W'(res);

endmodule
